@@ hdl/imuc_pkg.sv @@
// ----------------------------------------------------------------------------
// imuc_pkg
// Shared types, constants and arithmetic helpers for the IMU calibration and
// covariance block.
// ----------------------------------------------------------------------------
package imuc_pkg;

  localparam int AW    = 16;   // axis width, Q5.10
  localparam int NAX   = 3;
  localparam int VW    = 48;   // packed vector width
  localparam int CW    = 64;   // config data width
  localparam int CAW   = 3;    // config index width
  localparam int IDW   = 128;
  localparam int ODW   = 320;
  localparam int DW    = 31;   // variance entry width
  localparam int ACCW  = 66;   // accumulator width
  localparam int MW    = 32;   // multiplier operand width
  localparam int PW    = 64;   // product width
  localparam int CVW   = 16;   // covariance entry width
  localparam int EXW   = 10;   // extrapolation term width

  localparam longint AX_MAX = (longint'(1) <<< (AW - 1)) - 1;
  localparam longint AX_MIN = -AX_MAX - 1;

  localparam logic [CAW-1:0] REG_ROT0   = 3'd0;
  localparam logic [CAW-1:0] REG_ROT1   = 3'd1;
  localparam logic [CAW-1:0] REG_ROT2   = 3'd2;
  localparam logic [CAW-1:0] REG_SCALE  = 3'd3;
  localparam logic [CAW-1:0] REG_VAR    = 3'd4;
  localparam logic [CAW-1:0] REG_AEXT   = 3'd5;
  localparam logic [CAW-1:0] REG_REXT   = 3'd6;
  localparam logic [CAW-1:0] REG_INIT   = 3'd7;

  typedef enum logic [4:0] {
    OP_SCALE = 5'b00001,
    OP_ROT   = 5'b00010,
    OP_DSL   = 5'b00100,
    OP_RR    = 5'b01000,
    OP_COV   = 5'b10000
  } op_t;

  typedef struct packed {
    logic       load;
    logic       issue;
    op_t        op;
    logic       sel;    // 0 acc, 1 rate
    logic [2:0] p;      // output row or matrix pair
    logic [1:0] i;      // term index
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  // rounds half up by 14 bits and clamps to the axis range
  function automatic logic [AW-1:0] axis_round(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] t;
    t = (v + 66'sd8192) >>> 14;
    if (t > AX_MAX) t = AX_MAX;
    else if (t < AX_MIN) t = AX_MIN;
    return AW'(t);
  endfunction

  // rounds half up by 28 bits, diagonal clamps unsigned, off-diagonal signed
  function automatic logic [CVW-1:0] cov_round(input logic signed [ACCW-1:0] v,
                                               input logic diag);
    logic signed [ACCW-1:0] t;
    t = (v + (66'sd1 <<< 27)) >>> 28;
    if (diag) begin
      if (t > 66'sd65535) t = 66'sd65535;
      else if (t < 66'sd0) t = 66'sd0;
    end else begin
      if (t > 66'sd32767) t = 66'sd32767;
      else if (t < -66'sd32768) t = -66'sd32768;
    end
    return CVW'(t);
  endfunction

  // matrix row pairs: xx yy zz xy xz yz
  function automatic logic [1:0] pair_a(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd1;
      3'd4: r = 2'd2;
      3'd5: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/imuc_ctrl.sv @@
// ----------------------------------------------------------------------------
// imuc_ctrl
// Sequencer: steps the shared multiplier through scale, rotation, variance,
// matrix pair and covariance passes for one frame.
// ----------------------------------------------------------------------------
module imuc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output imuc_pkg::cmd_t cmd,
  input  imuc_pkg::sts_t sts
);
  import imuc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic       s_r, s_nxt;
  logic [2:0] p_r, p_nxt;
  logic [1:0] i_r, i_nxt;
  logic [2:0] pmax;
  logic       smax;

  always_comb begin
    case (op_r)
      OP_ROT:  pmax = 3'd2;
      OP_RR:   pmax = 3'd5;
      OP_COV:  pmax = 3'd5;
      default: pmax = 3'd0;
    endcase
    smax = (op_r == OP_ROT) || (op_r == OP_DSL) || (op_r == OP_COV);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    s_nxt     = s_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.sel   = s_r;
    cmd.p     = p_r;
    cmd.i     = i_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_SCALE;
          s_nxt     = 1'b0;
          p_nxt     = 3'd0;
          i_nxt     = 2'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (i_r != 2'd2) begin
          i_nxt = i_r + 2'd1;
        end else begin
          i_nxt = 2'd0;
          if (p_r != pmax) begin
            p_nxt = p_r + 3'd1;
          end else begin
            p_nxt = 3'd0;
            if (s_r != smax) begin
              s_nxt = 1'b1;
            end else begin
              s_nxt = 1'b0;
              case (op_r)
                OP_SCALE: op_nxt = OP_ROT;
                OP_ROT:   op_nxt = OP_DSL;
                OP_DSL:   op_nxt = OP_RR;
                OP_RR:    op_nxt = OP_COV;
                default:  state_nxt = ST_DRAIN;
              endcase
            end
          end
        end
      end
      ST_DRAIN: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_SCALE;
      s_r     <= 1'b0;
      p_r     <= 3'd0;
      i_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      s_r     <= s_nxt;
      p_r     <= p_nxt;
      i_r     <= i_nxt;
    end
  end

`ifndef SYNTH
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_RUN) else $error("load did not start run");
  a_drain_after_cov: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> $past(op_r) == OP_COV) else $error("drain before covariance");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.out_busy) else $error("push into busy output");
`endif

endmodule

@@ hdl/imuc_dp.sv @@
// ----------------------------------------------------------------------------
// imuc_dp
// Datapath: config registers, frame state, freshness decision, shared
// multiplier with accumulate stage, and the output register.
// ----------------------------------------------------------------------------
module imuc_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [imuc_pkg::CAW-1:0]  cfg_addr,
  input  logic [imuc_pkg::CW-1:0]   cfg_wdata,
  input  logic [imuc_pkg::IDW-1:0]  in_tdata,
  input  logic                      in_tuser,
  input  imuc_pkg::cmd_t            cmd,
  output imuc_pkg::sts_t            sts,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [imuc_pkg::ODW-1:0]  out_tdata,
  output logic [1:0]                out_tuser
);
  import imuc_pkg::*;

  // config
  logic [VW-1:0]      rot_r [NAX];
  logic [VW-1:0]      scale_r;
  logic [CW-1:0]      var_r;
  logic [6*EXW-1:0]   aext_r, rext_r;
  logic [CW-1:0]      init_r;

  // frame state
  logic [VW-1:0]      last_r [2];
  logic               pfresh_r [2];
  logic [AW-1:0]      ch_r [2][NAX];

  // per-frame work
  logic [VW-1:0]      vin_r [2];
  logic [31:0]        tilt_r;
  logic               fresh_r [2];
  logic [AW-1:0]      vr_r [NAX];
  logic [AW-1:0]      vout_r [2][NAX];
  logic [DW-1:0]      d_r [2][NAX];
  logic [MW-1:0]      rr_r [6][NAX];
  logic [CVW-1:0]     cov_r [2][6];
  logic signed [ACCW-1:0] acc_r;
  logic signed [PW-1:0]   prod_r;
  logic               v2_r;
  op_t                op2_r;
  logic               s2_r;
  logic [2:0]         p2_r;
  logic [1:0]         i2_r;

  logic               out_tvalid_r;
  logic [ODW-1:0]     out_tdata_r;
  logic [1:0]         out_tuser_r;

  // ---------------- freshness decision on load ----------------
  logic [VW-1:0]  raw [2];
  logic [VW-1:0]  lst [2];
  logic           pf [2];
  logic [AW-1:0]  init_v [2];
  logic [AW-1:0]  ch_nxt [2][NAX];
  logic           dif [2];
  logic           fr_nxt [2];
  logic           known, corr, nf;
  logic signed [AW:0] df;

  always_comb begin
    raw[0] = in_tdata[VW-1:0];
    raw[1] = in_tdata[2*VW-1:VW];
    init_v[0] = (|init_r[31:AW]) ? {AW{1'b1}} : init_r[AW-1:0];
    init_v[1] = (|init_r[63:32+AW]) ? {AW{1'b1}} : init_r[32+AW-1:32];
    df = '0;
    for (int s = 0; s < 2; s++) begin
      lst[s] = in_tuser ? '0 : last_r[s];
      pf[s]  = in_tuser ? 1'b0 : pfresh_r[s];
      dif[s] = lst[s] != raw[s];
      for (int a = 0; a < NAX; a++) ch_nxt[s][a] = in_tuser ? init_v[s] : ch_r[s][a];
    end
    if (!pf[0] && !pf[1]) begin
      nf = (lst[0] != '0) || (lst[1] != '0);
      fr_nxt[0] = nf && dif[0];
      fr_nxt[1] = nf && dif[1];
      known = fr_nxt[0] || fr_nxt[1];
    end else begin
      nf = 1'b1;
      fr_nxt[0] = !pf[0];
      fr_nxt[1] = !pf[1];
      known = 1'b1;
    end
    corr = (fr_nxt[0] && dif[1]) || (fr_nxt[1] && dif[0]) || (fr_nxt[0] == fr_nxt[1]);
    if (known) begin
      for (int s = 0; s < 2; s++) begin
        for (int a = 0; a < NAX; a++) begin
          df = {lst[s][a*AW+AW-1], lst[s][a*AW +: AW]}
             - {raw[s][a*AW+AW-1], raw[s][a*AW +: AW]};
          ch_nxt[s][a] = df[AW] ? AW'(-df) : df[AW-1:0];
        end
      end
      if (corr) begin
        for (int s = 0; s < 2; s++) begin
          fr_nxt[s] = dif[s];
          if (!dif[s]) begin
            for (int a = 0; a < NAX; a++) ch_nxt[s][a] = init_v[s];
          end
        end
      end
    end
  end

  // ---------------- multiplier stage ----------------
  logic signed [MW-1:0] opa, opb;

  function automatic logic signed [MW-1:0] mat(input logic [VW-1:0] row, input logic [1:0] i);
    return MW'($signed(row[16*i +: 16]));
  endfunction

  function automatic logic signed [MW-1:0] axv(input logic [VW-1:0] v, input logic [1:0] i);
    return MW'($signed(v[AW*i +: AW]));
  endfunction

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      OP_SCALE: begin
        opa = axv(vin_r[1], cmd.i);
        opb = MW'(scale_r[16*cmd.i +: 16]);
      end
      OP_ROT: begin
        opa = mat(rot_r[cmd.p[1:0]], cmd.i);
        opb = cmd.sel ? MW'($signed(vr_r[cmd.i])) : axv(vin_r[0], cmd.i);
      end
      OP_DSL: begin
        opa = MW'((cmd.sel ? rext_r : aext_r) >> (30 + EXW * cmd.i)) & MW'(10'h3FF);
        opb = MW'(ch_r[cmd.sel][cmd.i]);
      end
      OP_RR: begin
        opa = mat(rot_r[pair_a(cmd.p)], cmd.i);
        opb = mat(rot_r[pair_b(cmd.p)], cmd.i);
      end
      OP_COV: begin
        opa = rr_r[cmd.p][cmd.i];
        opb = MW'(d_r[cmd.sel][cmd.i]);
      end
      default: ;
    endcase
  end

  // ---------------- accumulate / writeback stage ----------------
  logic signed [ACCW-1:0] sum;
  logic [33:0]            dsum;
  logic [6*EXW-1:0]       ext2;

  always_comb begin
    sum  = ((i2_r == 2'd0) ? '0 : acc_r) + ACCW'(prod_r);
    ext2 = s2_r ? rext_r : aext_r;
    dsum = 34'(s2_r ? var_r[63:32] : var_r[31:0]);
    if (!fresh_r[s2_r]) begin
      dsum = dsum + 34'(ext2[EXW*i2_r +: EXW]) + 34'(prod_r[25:10]);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    op2_r  <= cmd.op;
    s2_r   <= cmd.sel;
    p2_r   <= cmd.p;
    i2_r   <= cmd.i;
    if (cmd.load) begin
      vin_r[0] <= raw[0];
      vin_r[1] <= raw[1];
      tilt_r   <= in_tdata[IDW-1:2*VW];
      fresh_r[0] <= fr_nxt[0];
      fresh_r[1] <= fr_nxt[1];
    end
    if (v2_r) begin
      case (op2_r)
        OP_SCALE: vr_r[i2_r] <= axis_round(ACCW'(prod_r));
        OP_ROT: begin
          acc_r <= sum;
          if (i2_r == 2'd2) vout_r[s2_r][p2_r[1:0]] <= axis_round(sum);
        end
        OP_DSL: d_r[s2_r][i2_r] <= (dsum > 34'h7FFFFFFF) ? 31'h7FFFFFFF : dsum[DW-1:0];
        OP_RR:  rr_r[p2_r][i2_r] <= prod_r[MW-1:0];
        OP_COV: begin
          acc_r <= sum;
          if (i2_r == 2'd2) cov_r[s2_r][p2_r] <= cov_round(sum, p2_r < 3'd3);
        end
        default: ;
      endcase
    end
    if (cmd.push) begin
      out_tdata_r <= {tilt_r,
                      cov_r[1][5], cov_r[1][4], cov_r[1][3],
                      cov_r[1][2], cov_r[1][1], cov_r[1][0],
                      cov_r[0][5], cov_r[0][4], cov_r[0][3],
                      cov_r[0][2], cov_r[0][1], cov_r[0][0],
                      vout_r[1][2], vout_r[1][1], vout_r[1][0],
                      vout_r[0][2], vout_r[0][1], vout_r[0][0]};
      out_tuser_r <= {fresh_r[1], fresh_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 48'h0000_0000_4000;
      rot_r[1] <= 48'h0000_4000_0000;
      rot_r[2] <= 48'h4000_0000_0000;
      scale_r  <= 48'h4000_4000_4000;
      var_r    <= '0;
      aext_r   <= '0;
      rext_r   <= '0;
      init_r   <= '0;
      for (int s = 0; s < 2; s++) begin
        last_r[s]   <= '0;
        pfresh_r[s] <= 1'b0;
        for (int a = 0; a < NAX; a++) ch_r[s][a] <= '0;
      end
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      v2_r <= cmd.issue;
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROT0:  rot_r[0] <= cfg_wdata[VW-1:0];
          REG_ROT1:  rot_r[1] <= cfg_wdata[VW-1:0];
          REG_ROT2:  rot_r[2] <= cfg_wdata[VW-1:0];
          REG_SCALE: scale_r  <= cfg_wdata[VW-1:0];
          REG_VAR:   var_r    <= cfg_wdata;
          REG_AEXT:  aext_r   <= cfg_wdata[6*EXW-1:0];
          REG_REXT:  rext_r   <= cfg_wdata[6*EXW-1:0];
          REG_INIT:  init_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        for (int s = 0; s < 2; s++) begin
          last_r[s]   <= raw[s];
          pfresh_r[s] <= fr_nxt[s];
          for (int a = 0; a < NAX; a++) ch_r[s][a] <= ch_nxt[s][a];
        end
      end
      if (cmd.push) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  assign sts.out_busy = out_tvalid_r && !out_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser    = out_tuser_r;

`ifndef SYNTH
  a_rise_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(cmd.push)) else $error("output valid without push");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> out_tvalid_r) else $error("result dropped on stall");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.issue && !v2_r) else $error("load during multiply pass");
`endif

endmodule

@@ hdl/imu_calibrate_and_covariance.sv @@
// ----------------------------------------------------------------------------
// imu_calibrate_and_covariance
// IMU frame calibration: freshness tracking, rate scaling, rotation and
// rotated measurement covariance, on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | beat fields (tdata low bit up)                        | tuser
//  in_      | raw_acc, raw_rate, tilt_angle                          | frames_dropped
//  out_     | acc_out, rate_out, acc/rate cov diag and off, angle    | acc_fresh, rate_fresh
//  cfg_     | index 0..7, data up to 64 bits                         | -
//
// a frame is accepted, then runs 81 multiplier passes (3 scale, 18 rotate,
// 6 variance, 18 matrix pair, 36 covariance), a drain and a push.
// the shared multiplier is the limit; one frame is in work at a time.
// the output register holds a result under stall while the next frame runs.
// synchronous active-low reset restores identity calibration and clears state.
module imu_calibrate_and_covariance (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [imuc_pkg::CAW-1:0]  cfg_addr,
  input  logic [imuc_pkg::CW-1:0]   cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [imuc_pkg::IDW-1:0]  in_tdata,   // raw_acc, raw_rate, tilt_angle
  input  logic                      in_tuser,   // frames_dropped
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // acc_out, rate_out, acc_cov_diag, acc_cov_off, rate_cov_diag, rate_cov_off, angle_out
  output logic [imuc_pkg::ODW-1:0]  out_tdata,
  output logic [1:0]                out_tuser   // acc_fresh, rate_fresh
);
  import imuc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  imuc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  imuc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ bench/imu_calibrate_and_covariance_checker.sv @@
// ----------------------------------------------------------------------------
// imu_calibrate_and_covariance_checker
// Watches the frame and result streams, predicts each calibrated result from
// the accepted frames and register writes, and compares every beat field.
// ----------------------------------------------------------------------------
module imu_calibrate_and_covariance_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [imuc_pkg::CAW-1:0]  cfg_addr,
  input  logic [imuc_pkg::CW-1:0]   cfg_wdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [imuc_pkg::IDW-1:0]  in_tdata,   // raw_acc, raw_rate, tilt_angle
  input  logic                      in_tuser,   // frames_dropped
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  // acc_out, rate_out, acc_cov_diag, acc_cov_off, rate_cov_diag, rate_cov_off, angle_out
  input  logic [imuc_pkg::ODW-1:0]  out_tdata,
  input  logic [1:0]                out_tuser,  // acc_fresh, rate_fresh
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen,
  output int                        stale_seen
);
  import imuc_pkg::*;

  typedef struct packed {
    logic [1:0]    fresh;
    logic [ODW-1:0] data;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [47:0] rot_row [3];
  logic [47:0] rate_scale;
  logic [63:0] noise_var, init_changes;
  logic [59:0] acc_ext, rate_ext;
  logic [47:0] last_acc, last_rate;
  logic        prev_af, prev_rf;
  longint      acc_chg [3];
  longint      rate_chg [3];

  function automatic longint axis_val(logic [47:0] v, int i);
    return longint'($signed(v[i*AW +: AW]));
  endfunction

  function automatic longint mcoef(int j, int i);
    return longint'($signed(rot_row[j][i*16 +: 16]));
  endfunction

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_init(logic [31:0] v);
    return v > 32'hFFFF ? 65535 : longint'(v);
  endfunction

  function automatic logic [47:0] rotate_vec(longint v [3]);
    logic [47:0] r;
    longint s;
    r = '0;
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += mcoef(j, i) * v[i];
      r[j*AW +: AW] = AW'(clamp(rshift_round(s, 14), AX_MIN, AX_MAX));
    end
    return r;
  endfunction

  // R*D*R^T; products may exceed 64 bits so sums are kept at 96
  function automatic logic [95:0] rotated_cov(logic [31:0] var_lsb, logic [59:0] ext,
                                              logic fresh, longint chg [3]);
    logic signed [95:0] d [3];
    logic signed [95:0] s, t, half;
    logic [95:0] packed_cov;
    longint v;
    int pj [3] = '{0, 0, 1};
    int pk [3] = '{1, 2, 2};
    half = 96'sd1 <<< 27;
    for (int i = 0; i < 3; i++) begin
      v = longint'(var_lsb);
      if (!fresh) v += longint'(ext[10*i +: 10]) + ((longint'(ext[30+10*i +: 10]) * chg[i]) >>> 10);
      d[i] = v > 64'sd2147483647 ? 96'sd2147483647 : 96'(v);
    end
    packed_cov = '0;
    for (int n = 0; n < 3; n++) begin
      s = 0;
      t = 0;
      for (int i = 0; i < 3; i++) begin
        s += 96'(mcoef(n, i) * mcoef(n, i)) * d[i];
        t += 96'(mcoef(pj[n], i) * mcoef(pk[n], i)) * d[i];
      end
      s = (s + half) >>> 28;
      t = (t + half) >>> 28;
      if (s > 65535) s = 65535; else if (s < 0) s = 0;
      if (t > 32767) t = 32767; else if (t < -32768) t = -32768;
      packed_cov[16*n +: 16] = s[15:0];
      packed_cov[48+16*n +: 16] = t[15:0];
    end
    return packed_cov;
  endfunction

  function automatic void load_chg(ref longint c [3], input logic [31:0] init);
    for (int i = 0; i < 3; i++) c[i] = sat_init(init);
  endfunction

  function automatic void diff_chg(ref longint c [3], input logic [47:0] a, logic [47:0] b);
    longint d;
    for (int i = 0; i < 3; i++) begin
      d = axis_val(a, i) - axis_val(b, i);
      c[i] = (d < 0 ? -d : d) & 64'hFFFF;
    end
  endfunction

  task automatic predict_frame(logic [IDW-1:0] beat, logic dropped);
    logic [47:0] racc, rrate;
    logic na, nr, known;
    longint va [3];
    longint vr [3];
    frame_result_t r;
    logic [95:0] ac, rc;
    racc  = beat[47:0];
    rrate = beat[95:48];
    known = 1'b1;
    if (dropped) begin
      prev_af = 0; prev_rf = 0; last_acc = '0; last_rate = '0;
      load_chg(acc_chg, init_changes[31:0]);
      load_chg(rate_chg, init_changes[63:32]);
    end
    if (!prev_af && !prev_rf) begin
      na = (last_acc != 0 || last_rate != 0) && last_acc != racc;
      nr = (last_acc != 0 || last_rate != 0) && last_rate != rrate;
      known = na || nr;
    end else begin
      na = !prev_af;
      nr = !prev_rf;
    end
    if (known) begin
      diff_chg(acc_chg, last_acc, racc);
      diff_chg(rate_chg, last_rate, rrate);
      // flags disagree with the data: trust the data
      if ((na && last_rate != rrate) || (nr && last_acc != racc) || na == nr) begin
        na = last_acc != racc;
        nr = last_rate != rrate;
        if (!na) load_chg(acc_chg, init_changes[31:0]);
        if (!nr) load_chg(rate_chg, init_changes[63:32]);
      end
    end
    last_acc = racc; last_rate = rrate; prev_af = na; prev_rf = nr;
    for (int i = 0; i < 3; i++) begin
      va[i] = axis_val(racc, i);
      vr[i] = clamp(rshift_round(axis_val(rrate, i) * longint'(rate_scale[16*i +: 16]), 14),
                    AX_MIN, AX_MAX);
    end
    ac = rotated_cov(noise_var[31:0], acc_ext, na, acc_chg);
    rc = rotated_cov(noise_var[63:32], rate_ext, nr, rate_chg);
    r.fresh = {nr, na};
    r.data = {beat[127:96], rc[95:48], rc[47:0], ac[95:48], ac[47:0],
              rotate_vec(vr), rotate_vec(va)};
    expected_results.push_back(r);
  endtask

  task automatic report(string what, logic [ODW-1:0] got, logic [ODW-1:0] want);
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
    fail_count++;
  endtask

  string field_name [7] = '{"acc_out", "rate_out", "acc_cov_diag", "acc_cov_off",
                             "rate_cov_diag", "rate_cov_off", "angle_out"};

  initial begin
    fail_count = 0; results_seen = 0; stale_seen = 0; pending = 0;
  end

  always @(posedge clk) begin
    frame_result_t e;
    int w;
    if (!rst_n) begin
      rot_row[0] = 48'd16384; rot_row[1] = 48'd16384 << 16; rot_row[2] = 48'd16384 << 32;
      rate_scale = {16'd16384, 16'd16384, 16'd16384};
      noise_var = '0; acc_ext = '0; rate_ext = '0; init_changes = '0;
      last_acc = '0; last_rate = '0; prev_af = 0; prev_rf = 0;
      for (int i = 0; i < 3; i++) begin acc_chg[i] = 0; rate_chg[i] = 0; end
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result beat %0h", out_tdata);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          for (int f = 0; f < 7; f++) begin
            w = f == 6 ? 32 : 48;
            if (((out_tdata >> (48*f)) & ((320'd1 << w) - 1)) !=
                ((e.data >> (48*f)) & ((320'd1 << w) - 1)))
              report(field_name[f], (out_tdata >> (48*f)) & ((320'd1 << w) - 1),
                     (e.data >> (48*f)) & ((320'd1 << w) - 1));
          end
          if (out_tuser[0] != e.fresh[0]) report("acc_fresh", out_tuser[0], e.fresh[0]);
          if (out_tuser[1] != e.fresh[1]) report("rate_fresh", out_tuser[1], e.fresh[1]);
          if (e.fresh != 2'b11) stale_seen++;
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) predict_frame(in_tdata, in_tuser);
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROT0:  rot_row[0] = cfg_wdata[47:0];
          REG_ROT1:  rot_row[1] = cfg_wdata[47:0];
          REG_ROT2:  rot_row[2] = cfg_wdata[47:0];
          REG_SCALE: rate_scale = cfg_wdata[47:0];
          REG_VAR:   noise_var = cfg_wdata;
          REG_AEXT:  acc_ext = cfg_wdata[59:0];
          REG_REXT:  rate_ext = cfg_wdata[59:0];
          default:   init_changes = cfg_wdata;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ bench/imu_calibrate_and_covariance_tb.sv @@
// ----------------------------------------------------------------------------
// imu_calibrate_and_covariance_tb
// Drives IMU frames through the calibration block under bursty input and a
// stalling output, across several calibration settings including extremes.
// ----------------------------------------------------------------------------
module imu_calibrate_and_covariance_tb;
  import imuc_pkg::*;

  localparam int RANDOM_FRAMES = 1530;
  localparam int STALL_LIMIT   = 20000;

  logic            clk, rst_n;
  logic            cfg_we;
  logic [CAW-1:0]  cfg_addr;
  logic [CW-1:0]   cfg_wdata;
  logic            in_tvalid, in_tready;
  logic [IDW-1:0]  in_tdata;
  logic            in_tuser;
  logic            out_tvalid, out_tready;
  logic [ODW-1:0]  out_tdata;
  logic [1:0]      out_tuser;
  int              fail_count, pending, results_seen, stale_seen;
  int              idle_cycles;
  logic            hold_off;
  logic [47:0]     cur_acc, cur_rate;

  imu_calibrate_and_covariance i_dut (.*);

  imu_calibrate_and_covariance_checker i_checker (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .in_tvalid, .in_tready, .in_tdata,
    .in_tuser, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .fail_count,
    .pending, .results_seen, .stale_seen
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall pattern, plus a long hold-off on request
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else out_tready <= ($urandom_range(3) != 0) || ($urandom_range(7) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [47:0] rand_vec();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(5))
      0: v = {16'h7FFF, 16'h8000, 16'hFFFF};
      1: v = {3{16'($urandom_range(4095) - 2048)}};
      default: ;
    endcase
    return v;
  endfunction

  // tready only moves at the rising edge, so its value here holds for the next edge
  task automatic send_frame(logic [47:0] acc, logic [47:0] rate, logic dropped);
    in_tvalid <= 1;
    in_tdata  <= {$urandom, rate, acc};
    in_tuser  <= dropped;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    if ($urandom_range(3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(40)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [CAW-1:0] idx, logic [63:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // alternating sensors: one vector changes per frame, with noise mixed in
  task automatic frame_sequence(int n);
    logic turn;
    turn = 1'($urandom_range(1));
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send_frame(rand_vec(), rand_vec(), $urandom_range(15) == 0);
        1: send_frame(cur_acc, cur_rate, 1'b0);
        2: send_frame(48'd0, 48'd0, 1'($urandom_range(1)));
        default: begin
          if (turn) cur_acc = rand_vec(); else cur_rate = rand_vec();
          send_frame(cur_acc, cur_rate, 1'b0);
          turn = ~turn;
        end
      endcase
      gap();
    end
  endtask

  task automatic random_setting();
    write_reg(REG_ROT0, {$urandom, $urandom});
    write_reg(REG_ROT1, {$urandom, $urandom});
    write_reg(REG_ROT2, {$urandom, $urandom});
    write_reg(REG_SCALE, {$urandom, $urandom});
    write_reg(REG_VAR, {$urandom, $urandom} >> $urandom_range(63));
    write_reg(REG_AEXT, {$urandom, $urandom});
    write_reg(REG_REXT, {$urandom, $urandom});
    write_reg(REG_INIT, {$urandom, $urandom} >> $urandom_range(63));
  endtask

  initial begin
    hold_off = 0; idle_cycles = 0;
    rst_n = 0; cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    in_tvalid = 0; in_tdata = '0; in_tuser = 0;
    cur_acc = '0; cur_rate = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // reset setting: first frame, alternation, both change, no change, drop
    send_frame(48'd0, 48'd0, 1'b0);
    send_frame(48'h1234_5678_9ABC, 48'h0, 1'b0);
    send_frame(48'h1234_5678_9ABC, 48'h7FFF_8000_0001, 1'b0);
    send_frame(48'h0001_0002_0003, 48'h7FFF_8000_0001, 1'b0);
    send_frame(48'h0001_0002_0003, 48'h7FFF_8000_0001, 1'b0);
    send_frame(48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000, 1'b0);
    send_frame(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 1'b1);
    drain();

    // extremes: full-scale matrix and scale, saturating variances and changes
    write_reg(REG_ROT0, 64'h0000_8000_7FFF_8000);
    write_reg(REG_ROT1, 64'h0000_7FFF_7FFF_7FFF);
    write_reg(REG_ROT2, 64'h0000_FFFF_8000_0001);
    write_reg(REG_SCALE, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(REG_VAR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_AEXT, 64'h0FFF_FFFF_FFFF_FFFF);
    write_reg(REG_REXT, 64'h0FFF_FFFF_FFFF_FFFF);
    write_reg(REG_INIT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 1'b1);
    send_frame(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 1'b0);
    send_frame(48'h8000_8000_8000, 48'h8000_8000_8000, 1'b0);
    send_frame(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 1'b0);
    send_frame(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 1'b0);
    drain();
    write_reg(REG_VAR, 64'h0000_0100_0000_0040);
    write_reg(REG_AEXT, 64'h00FF_0012_0015_53FF);
    write_reg(REG_REXT, 64'h03FF_2AA0_FF10_0001);
    write_reg(REG_INIT, 64'h0000_4000_0001_0000);
    frame_sequence(8);

    // long output hold-off while frames keep coming
    fork
      begin
        hold_off = 1;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      frame_sequence(10);
    join
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_setting();
      frame_sequence(RANDOM_FRAMES / 6);
      drain();
    end

    $display("%0d result beats checked over 9 calibration settings, %0d with a stale sensor",
             results_seen, stale_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
